// File: hdl/bmde_pkg.sv
package bmde_pkg;

  localparam int unsigned MV_W    = 14;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DISP_W  = 29;
  localparam int unsigned SEG_W   = 7;

  localparam logic [MV_W-1:0]  MV_LOW       = 14'd3000;
  localparam logic [MV_W-1:0]  MV_HIGH      = 14'd3800;
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;

  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SH    = 19;
  localparam logic [12:0] DIV100_MUL  = 13'd5243;
  localparam int unsigned DIV100_SH   = 19;
  localparam logic [13:0] DIV1000_MUL = 14'd8389;
  localparam int unsigned DIV1000_SH  = 23;
  localparam logic [7:0]  PDIV10_MUL  = 8'd205;
  localparam int unsigned PDIV10_SH   = 11;

  localparam int unsigned STATUS_PMODE_BIT = 2;

  localparam int unsigned POS_MID   = 7;
  localparam int unsigned POS_TOP   = 14;
  localparam int unsigned POS_PCT   = 21;
  localparam int unsigned POS_VOLT  = 22;
  localparam int unsigned POS_DP    = 23;
  localparam int unsigned POS_BAR0  = 24;

  localparam logic [PCT_W-1:0] BAR_LEVEL0 = 7'd5;
  localparam logic [PCT_W-1:0] BAR_LEVEL1 = 7'd30;
  localparam logic [PCT_W-1:0] BAR_LEVEL2 = 7'd50;
  localparam logic [PCT_W-1:0] BAR_LEVEL3 = 7'd70;
  localparam logic [PCT_W-1:0] BAR_LEVEL4 = 7'd90;

  typedef struct packed {
    logic signed [15:0] voltage_reading;
    logic [7:0]         status_bits;
  } in_item_t;

  typedef struct packed {
    logic [DISP_W-1:0] display_bits;
    logic              wiring_error;
    logic [MV_W-1:0]   millivolts;
    logic [PCT_W-1:0]  percent_level;
    logic              percent_mode;
  } out_item_t;

  typedef struct packed {
    logic             error;
    logic             pmode;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic [3:0]       pct_tens;
    logic [10:0]      q_r10;
    logic [7:0]       q_r100;
    logic [7:0]       q100;
    logic [4:0]       q1000;
  } entry_t;

  function automatic logic [SEG_W-1:0] seg7(input logic [3:0] digit);
    logic [SEG_W-1:0] pattern;
    case (digit)
      4'd0: pattern = 7'b0111111;
      4'd1: pattern = 7'b0000110;
      4'd2: pattern = 7'b1011011;
      4'd3: pattern = 7'b1001111;
      4'd4: pattern = 7'b1100110;
      4'd5: pattern = 7'b1101101;
      4'd6: pattern = 7'b1111101;
      4'd7: pattern = 7'b0000111;
      4'd8: pattern = 7'b1111111;
      4'd9: pattern = 7'b1101111;
      default: pattern = '0;
    endcase
    return pattern;
  endfunction

endpackage

// File: hdl/bmde_stream_if.sv
interface bmde_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/battery_meter_display_encoder.sv
// channel  modport  payload                                        role
// sample   sink     voltage_reading, status_bits                   sensor samples in
// result   source   display_bits, wiring_error, millivolts,        display word out
//                   percent_level, percent_mode
//
// One transfer per cycle while result is ready; path: queue slot, output register.
// The front does the constant-reciprocal multiplies, the back the digit and segment logic.
// Reset clears the queue, the output valid and the held display word.
// A stall on result fills the QUEUE_DEPTH-entry queue before sample.ready drops.
module battery_meter_display_encoder import bmde_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  bmde_stream_if.sink   sample,
  bmde_stream_if.source result
);

  logic   room;
  logic   push;
  logic   pop;
  logic   have;
  entry_t entry;
  entry_t head;

  bmde_front u_front (
    .sample (sample),
    .room   (room),
    .push   (push),
    .entry  (entry)
  );

  bmde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .room  (room),
    .pop   (pop),
    .have  (have),
    .head  (head)
  );

  bmde_back u_back (
    .clk    (clk),
    .rst    (rst),
    .have   (have),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: hdl/bmde_front.sv
module bmde_front import bmde_pkg::*; (
  bmde_stream_if.sink sample,
  input  logic        room,
  output logic        push,
  output entry_t      entry
);

  logic [MV_W-1:0] mv;
  logic [14:0]     mv5;
  logic [30:0]     p_r10;
  logic [27:0]     p_r100;
  logic [27:0]     p100;
  logic [27:0]     p1000;
  logic [MV_W-1:0] mv_off;
  logic [PCT_W-1:0] pct;
  logic [14:0]     p_ptens;

  assign sample.ready = room;
  assign push         = sample.valid && room;

  assign mv  = sample.data.voltage_reading[14:1];
  assign mv5 = {1'b0, mv} + 15'd5;

  assign p_r10  = 31'(mv5) * 31'(DIV10_MUL);
  assign p_r100 = 28'(mv5) * 28'(DIV100_MUL);
  assign p100   = 28'(mv)  * 28'(DIV100_MUL);
  assign p1000  = 28'(mv)  * 28'(DIV1000_MUL);

  assign mv_off = mv - MV_LOW;

  always_comb begin
    if (mv < MV_LOW) begin
      pct = '0;
    end else if (mv > MV_HIGH) begin
      pct = PCT_FULL;
    end else begin
      pct = mv_off[9:3];
    end
  end

  assign p_ptens = 15'(pct) * 15'(PDIV10_MUL);

  always_comb begin
    entry.error    = sample.data.voltage_reading[15];
    entry.pmode    = sample.data.status_bits[STATUS_PMODE_BIT];
    entry.mv       = mv;
    entry.pct      = pct;
    entry.pct_tens = p_ptens[PDIV10_SH +: 4];
    entry.q_r10    = p_r10[DIV10_SH +: 11];
    entry.q_r100   = p_r100[DIV100_SH +: 8];
    entry.q100     = p100[DIV100_SH +: 8];
    entry.q1000    = p1000[DIV1000_SH +: 5];
  end

endmodule

// File: hdl/bmde_queue.sv
module bmde_queue import bmde_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t entry,
  output logic   room,
  input  logic   pop,
  output logic   have,
  output entry_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign room = count != CNT_W'(DEPTH);
  assign have = count != '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !room |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !have |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: hdl/bmde_back.sv
module bmde_back import bmde_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          have,
  input  entry_t        head,
  output logic          pop,
  bmde_stream_if.source result
);

  logic [DISP_W-1:0] held;
  logic [DISP_W-1:0] word;
  logic [3:0]        v_right;
  logic [3:0]        v_mid;
  logic [3:0]        v_top;
  logic [10:0]       r_sub;
  logic [7:0]        m_sub;
  logic [3:0]        p_units;
  logic [3:0]        p_mid;
  logic [6:0]        p_sub;
  logic [4:0]        bars;
  logic              full;

  assign pop = have && (!result.valid || result.ready);

  assign r_sub = head.q_r10 - ({head.q_r100, 3'b000} + {2'b00, head.q_r100, 1'b0});
  assign m_sub = head.q100 - ({head.q1000, 3'b000} + {2'b00, head.q1000, 1'b0});
  assign v_right = r_sub[3:0];
  assign v_mid   = m_sub[3:0];
  assign v_top   = (head.q1000 >= 5'd10) ? 4'(head.q1000 - 5'd10) : head.q1000[3:0];

  assign p_sub   = head.pct - ({head.pct_tens, 3'b000} + {2'b00, head.pct_tens, 1'b0});
  assign p_units = p_sub[3:0];
  assign full    = head.pct == PCT_FULL;
  assign p_mid   = full ? 4'd0 : head.pct_tens;

  assign bars = {head.pct >= BAR_LEVEL4, head.pct >= BAR_LEVEL3, head.pct >= BAR_LEVEL2,
                 head.pct >= BAR_LEVEL1, head.pct >= BAR_LEVEL0};

  always_comb begin
    word = '0;
    if (!head.pmode) begin
      word[0 +: SEG_W]       = seg7(v_right);
      word[POS_MID +: SEG_W] = seg7(v_mid);
      word[POS_TOP +: SEG_W] = seg7(v_top);
      word[POS_VOLT]         = 1'b1;
      word[POS_DP]           = 1'b1;
    end else begin
      word[0 +: SEG_W] = seg7(p_units);
      if (p_mid != 4'd0 || full) begin
        word[POS_MID +: SEG_W] = seg7(p_mid);
      end
      if (full) begin
        word[POS_TOP +: SEG_W] = seg7(4'd1);
      end
      word[POS_PCT] = 1'b1;
    end
    word[POS_BAR0 +: 5] = bars;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (pop && !head.error) begin
      held <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.error) begin
        result.data.display_bits  <= held;
        result.data.wiring_error  <= 1'b1;
        result.data.millivolts    <= '0;
        result.data.percent_level <= '0;
        result.data.percent_mode  <= 1'b0;
      end else begin
        result.data.display_bits  <= word;
        result.data.wiring_error  <= 1'b0;
        result.data.millivolts    <= head.mv;
        result.data.percent_level <= head.pct;
        result.data.percent_mode  <= head.pmode;
      end
    end
  end

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
      pop && head.error |=> result.data.display_bits == $past(held))
    else $error("error transfer did not show held word");
  a_held_tracks: assert property (@(posedge clk) disable iff (rst)
      pop && !head.error |=> held == result.data.display_bits)
    else $error("held word differs from shown word");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
      result.valid && result.data.wiring_error |->
      result.data.millivolts == '0 && result.data.percent_level == '0 &&
      !result.data.percent_mode)
    else $error("error result carries nonzero fields");

endmodule

// File: test/tb_battery_meter_display_encoder.sv
`timescale 1ns / 1ps

module tb_battery_meter_display_encoder;
  import bmde_pkg::*;

  localparam int RANDOM_SAMPLES = 1650;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int GAP_TOP        = 17;

  localparam logic [69:0] SEG_ROM = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct {
    in_item_t sample;
    bit       drain;
  } pending_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmde_stream_if #(.payload_t(in_item_t))  sample_ch ();
  bmde_stream_if #(.payload_t(out_item_t)) result_ch ();

  battery_meter_display_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  pending_sample_t   sample_backlog[$];
  out_item_t         display_due[$];
  logic [DISP_W-1:0] held_word = '0;

  bit        sample_fire = 1'b0;
  bit        result_fire = 1'b0;
  bit        sending     = 1'b0;
  int        send_gap    = 0;
  int        gap_max     = GAP_TOP;
  int        stall_left  = 0;
  int        stall_max   = GAP_TOP;
  int        n_sent      = 0;
  int        n_checked   = 0;
  int        n_bad       = 0;
  int        n_volts     = 0;
  int        n_percent   = 0;
  int        n_miswired  = 0;
  int        cycles      = 0;
  out_item_t want;
  out_item_t got;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SEG_W-1:0] digit_segments(input int unsigned value);
    return SEG_ROM[7*value +: 7];
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return GAP_TOP;
    endcase
  endfunction

  function automatic out_item_t encode_sample(input in_item_t s);
    out_item_t   r;
    int unsigned mv;
    int unsigned pct;
    int unsigned mid;
    logic [31:0] word;
    r = '0;
    if (s.voltage_reading[15]) begin
      r.display_bits = held_word;
      r.wiring_error = 1'b1;
      return r;
    end
    mv = 32'(s.voltage_reading[14:1]);
    if (mv < 3000)
      pct = 0;
    else if (mv > 3800)
      pct = 100;
    else
      pct = (mv - 3000) / 8;
    word = '0;
    if (!s.status_bits[STATUS_PMODE_BIT]) begin
      word[6:0]   = digit_segments(((mv + 5) / 10) % 10);
      word[13:7]  = digit_segments((mv / 100) % 10);
      word[20:14] = digit_segments((mv / 1000) % 10);
      word[22]    = 1'b1;
      word[23]    = 1'b1;
    end else begin
      mid = (pct / 10) % 10;
      word[6:0] = digit_segments(pct % 10);
      if (mid != 0 || pct >= 100)
        word[13:7] = digit_segments(mid);
      if (pct >= 100)
        word[20:14] = digit_segments(pct / 100);
      word[21] = 1'b1;
    end
    word[24] = (pct >= 5);
    word[25] = (pct >= 30);
    word[26] = (pct >= 50);
    word[27] = (pct >= 70);
    word[28] = (pct >= 90);
    held_word       = word[DISP_W-1:0];
    r.display_bits  = word[DISP_W-1:0];
    r.millivolts    = mv[MV_W-1:0];
    r.percent_level = pct[PCT_W-1:0];
    r.percent_mode  = s.status_bits[STATUS_PMODE_BIT];
    return r;
  endfunction

  task automatic queue_sample(input logic [15:0] reading, input logic [7:0] status,
                              input bit drain);
    pending_sample_t p;
    p.sample.voltage_reading = reading;
    p.sample.status_bits     = status;
    p.drain                  = drain;
    sample_backlog.push_back(p);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_fire) begin
        sending  = 1'b0;
        send_gap = $urandom_range(0, gap_max);
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_backlog.size() != 0 &&
                     !(sample_backlog[0].drain && display_due.size() != 0)) begin
          sample_ch.data <= sample_backlog[0].sample;
          sample_backlog.pop_front();
          sending = 1'b1;
          n_sent++;
          if (n_sent % 150 == 0)
            gap_max = pick_gap_max();
        end
      end
      sample_ch.valid <= sending;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_fire) begin
        if (n_checked % 150 == 0)
          stall_max = pick_gap_max();
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sample_fire <= !rst && sample_ch.valid && sample_ch.ready;
    result_fire <= !rst && result_ch.valid && result_ch.ready;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      display_due.push_back(encode_sample(sample_ch.data));
      if (sample_ch.data.voltage_reading[15])
        n_miswired++;
      else if (sample_ch.data.status_bits[STATUS_PMODE_BIT])
        n_percent++;
      else
        n_volts++;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      n_checked++;
      if (display_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result %0d arrived with nothing pending: disp=%h err=%b mv=%0d",
                   n_checked, got.display_bits, got.wiring_error, got.millivolts);
      end else begin
        want = display_due.pop_front();
        if (got.display_bits !== want.display_bits ||
            got.wiring_error !== want.wiring_error ||
            got.millivolts !== want.millivolts ||
            got.percent_level !== want.percent_level ||
            got.percent_mode !== want.percent_mode) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("result %0d want disp=%h err=%b mv=%0d pct=%0d pm=%b",
                     n_checked, want.display_bits, want.wiring_error, want.millivolts,
                     want.percent_level, want.percent_mode);
            $display("result %0d got  disp=%h err=%b mv=%0d pct=%0d pm=%b",
                     n_checked, got.display_bits, got.wiring_error, got.millivolts,
                     got.percent_level, got.percent_mode);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               display_due.size());
      $display("[battery_meter_display_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    logic [15:0] reading;

    queue_sample(16'hFFFF, 8'h00, 1'b0);
    queue_sample(16'd0,     8'h00, 1'b0);
    queue_sample(16'd0,     8'h04, 1'b0);
    queue_sample(16'h7FFF, 8'h00, 1'b0);
    queue_sample(16'h7FFF, 8'hFF, 1'b0);
    queue_sample(16'h8000, 8'hFF, 1'b0);
    queue_sample(16'd5998,  8'h04, 1'b0);
    queue_sample(16'd6000,  8'hFB, 1'b0);
    queue_sample(16'd6079,  8'h04, 1'b0);
    queue_sample(16'd6080,  8'h04, 1'b0);
    queue_sample(16'd6160,  8'h04, 1'b1);
    queue_sample(16'd6480,  8'h04, 1'b0);
    queue_sample(16'd6800,  8'h04, 1'b0);
    queue_sample(16'd7120,  8'h04, 1'b0);
    queue_sample(16'd7440,  8'h04, 1'b0);
    queue_sample(16'd7584,  8'h04, 1'b0);
    queue_sample(16'd7600,  8'h04, 1'b0);
    queue_sample(16'd7602,  8'h00, 1'b0);
    queue_sample(16'd7990,  8'h00, 1'b0);
    queue_sample(16'd7989,  8'h00, 1'b0);
    queue_sample(16'd7001,  8'h00, 1'b0);
    queue_sample(16'd19999, 8'h00, 1'b0);
    queue_sample(16'd20000, 8'h00, 1'b0);
    queue_sample(16'h8001, 8'h04, 1'b0);
    queue_sample(16'd6000,  8'h04, 1'b0);

    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8)
        reading = 16'($urandom_range(5800, 7800));
      else if (sel < 11)
        reading = 16'($urandom_range(0, 32767));
      else if (sel < 14)
        reading = 16'($urandom_range(32768, 65535));
      else
        reading = 16'($urandom());
      queue_sample(reading, 8'($urandom_range(0, 255)), (i % 400) == 399);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (sample_backlog.size() != 0 || sample_ch.valid || display_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d samples sent: %0d volts mode, %0d percent mode, %0d miswired",
             n_sent, n_volts, n_percent, n_miswired);
    $display("%0d results checked under random sender gaps and receiver stalls",
             n_checked);
    if (n_bad == 0 && display_due.size() == 0)
      $display("[battery_meter_display_encoder] OK");
    else
      $display("[battery_meter_display_encoder] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bmde_pkg.sv
hdl/bmde_stream_if.sv
hdl/bmde_front.sv
hdl/bmde_queue.sv
hdl/bmde_back.sv
hdl/battery_meter_display_encoder.sv
test/tb_battery_meter_display_encoder.sv
